[sv/wqds_pkg.sv]
package wqds_pkg;

  localparam int COUNT_BITS = 24;
  localparam int PULSE_W    = 24;
  localparam int REV_W      = 24;
  localparam int MAX_STOPS  = 10;
  localparam int STOP_W     = 4;
  localparam int NSTOP_W    = 5;
  localparam int PHASE_W    = 4;
  localparam int DEPTH_W    = 11;
  localparam int CPR_W      = 12;
  localparam int TPM_W      = 16;
  localparam int MS_W       = 16;
  localparam int WAIT_W     = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 3;

  localparam int THR_W = STOP_W + 1 + TPM_W;
  localparam int CMP_W = COUNT_BITS + 8;

  localparam int DIV_DIGIT = 4;
  localparam int DIV_STEPS = (COUNT_BITS + DIV_DIGIT - 1) / DIV_DIGIT;
  localparam int DIV_W     = DIV_STEPS * DIV_DIGIT;
  localparam int DIV_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam int DEPTH_MIN   = 100;
  localparam int DEPTH_OFS   = 50;
  localparam int RECIP_W     = 13;
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;

  localparam logic [DEPTH_W-1:0] DEPTH_RST  = DEPTH_W'(150);
  localparam logic [CPR_W-1:0]   CPR_RST    = CPR_W'(490);
  localparam logic [TPM_W-1:0]   TPM_RST    = TPM_W'(1358);
  localparam logic [MS_W-1:0]    DWELL_RST  = MS_W'(5000);
  localparam logic [MS_W-1:0]    HOME_RST   = MS_W'(1000);
  localparam logic [MS_W-1:0]    RETURN_RST = MS_W'(2000);

  localparam logic signed [1:0] QUAD_STEP [16] = '{
    2'sb00, 2'sb11, 2'sb01, 2'sb00,
    2'sb01, 2'sb00, 2'sb00, 2'sb11,
    2'sb11, 2'sb00, 2'sb00, 2'sb01,
    2'sb00, 2'sb01, 2'sb11, 2'sb00
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEPTH_CM,
    CFG_COUNTS_PER_REV,
    CFG_TURNS_PER_METER,
    CFG_DWELL_MS,
    CFG_HOME_SETTLE_MS,
    CFG_RETURN_SETTLE_MS
  } cfg_idx_e;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE,
    PH_HOMING,
    PH_SETTLE_HOME,
    PH_LOWERING,
    PH_DWELL,
    PH_RETURNING,
    PH_SETTLE_RETURN,
    PH_FINAL_TURN,
    PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_COUNT,
    CS_DIV_START,
    CS_DIV_WAIT,
    CS_PHASE,
    CS_THRESHOLD,
    CS_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic hall_a;
    logic hall_b;
    logic home_switch;
    logic ms_tick;
    logic start_req;
  } in_item_t;

  typedef struct packed {
    logic                      motor_up;
    logic                      motor_down;
    logic signed [PULSE_W-1:0] pulse_count;
    logic signed [REV_W-1:0]   revolutions;
    logic [PHASE_W-1:0]        phase;
    logic [STOP_W-1:0]         reached_meter;
    logic                      rejected;
  } out_item_t;

  typedef struct packed {
    logic   latch;
    logic   count;
    logic   div_start;
    logic   thr;
    logic   wait_step;
    logic   wait_clr;
    logic   stop_clr;
    logic   stop_inc;
    logic   stop_load;
    logic   reject_set;
    logic   reject_clr;
    logic   emit;
    phase_e phase;
  } dp_cmd_t;

  typedef struct packed {
    logic home;
    logic start;
    logic wait_done;
    logic below;
    logic revs_pos;
    logic depth_ok;
    logic stops_any;
    logic stop_more;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

[sv/wqds_in_if.sv]
interface wqds_in_if;
  logic               valid;
  logic               ready;
  wqds_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/wqds_out_if.sv]
interface wqds_out_if;
  logic                valid;
  logic                ready;
  wqds_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/wqds_divider.sv]
module wqds_divider (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic signed [wqds_pkg::COUNT_BITS-1:0]  dividend_i,
  input  logic [wqds_pkg::CPR_W-1:0]              divisor_i,
  output logic                                    done_o,
  output logic signed [wqds_pkg::COUNT_BITS-1:0]  quotient_o
);

  logic                                   busy_q, fix_q, done_q, neg_q;
  logic [wqds_pkg::DIV_CNT_W-1:0]         cnt_q;
  logic [wqds_pkg::CPR_W-1:0]             rem_q, rem_d;
  logic [wqds_pkg::DIV_W-1:0]             shf_q, shf_d;
  logic signed [wqds_pkg::COUNT_BITS-1:0] quo_q;
  logic [wqds_pkg::COUNT_BITS-1:0]        mag;

  assign mag = dividend_i[wqds_pkg::COUNT_BITS-1] ? -dividend_i : dividend_i;

  always_comb begin
    logic [wqds_pkg::CPR_W:0]   t;
    logic [wqds_pkg::CPR_W-1:0] r;
    logic [wqds_pkg::DIV_W-1:0] s;
    r = rem_q;
    s = shf_q;
    for (int i = 0; i < wqds_pkg::DIV_DIGIT; i++) begin
      t = {r, s[wqds_pkg::DIV_W-1]};
      s = {s[wqds_pkg::DIV_W-2:0], 1'b0};
      if (t >= {1'b0, divisor_i}) begin
        t = t - {1'b0, divisor_i};
        s[0] = 1'b1;
      end
      r = t[wqds_pkg::CPR_W-1:0];
    end
    rem_d = r;
    shf_d = s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fix_q;
      fix_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == wqds_pkg::DIV_CNT_W'(wqds_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          fix_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[wqds_pkg::COUNT_BITS-1];
      rem_q <= '0;
      shf_q <= wqds_pkg::DIV_W'(mag);
    end else if (busy_q) begin
      rem_q <= rem_d;
      shf_q <= shf_d;
    end
    if (fix_q) begin
      quo_q <= neg_q ? -shf_q[wqds_pkg::COUNT_BITS-1:0] : shf_q[wqds_pkg::COUNT_BITS-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[sv/wqds_datapath.sv]
module wqds_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wqds_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [wqds_pkg::CFG_W-1:0]       cfg_data_i,
  input  wqds_pkg::in_item_t               in_data_i,
  output wqds_pkg::out_item_t              out_data_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  input  wqds_pkg::dp_cmd_t                cmd_i,
  output wqds_pkg::dp_status_t             status_o
);

  logic [wqds_pkg::DEPTH_W-1:0] depth_q;
  logic [wqds_pkg::CPR_W-1:0]   cpr_q;
  logic [wqds_pkg::TPM_W-1:0]   tpm_q;
  logic [wqds_pkg::MS_W-1:0]    dwell_q, home_ms_q, return_ms_q;

  wqds_pkg::in_item_t                     in_q;
  logic                                   prev_a_q, prev_b_q;
  logic signed [wqds_pkg::COUNT_BITS-1:0] pulse_q, pulse_d;
  logic [wqds_pkg::STOP_W-1:0]            stop_q, stop_total_q, stop_next, stops_calc;
  logic [wqds_pkg::WAIT_W-1:0]            wait_q, wait_inc;
  logic                                   reject_q;
  logic [wqds_pkg::THR_W-1:0]             thr_q;
  wqds_pkg::out_item_t                    out_q, out_d;
  logic                                   out_valid_q;

  logic [3:0]                             quad_idx;
  logic signed [wqds_pkg::COUNT_BITS:0]   sum;
  logic signed [wqds_pkg::COUNT_BITS-1:0] base;
  logic signed [wqds_pkg::COUNT_BITS-1:0] revs;
  logic [wqds_pkg::CPR_W-1:0]             divisor;
  logic                                   div_done;
  logic signed [wqds_pkg::CMP_W-1:0]      cmp_lhs, cmp_rhs;
  logic                                   below, revs_pos;
  logic [wqds_pkg::MS_W-1:0]              limit;
  logic [wqds_pkg::DEPTH_W-1:0]           depth_ofs;
  logic [wqds_pkg::DEPTH_W+wqds_pkg::RECIP_W-1:0] depth_prod;
  logic [wqds_pkg::NSTOP_W-1:0]           nstops;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= wqds_pkg::DEPTH_RST;
      cpr_q       <= wqds_pkg::CPR_RST;
      tpm_q       <= wqds_pkg::TPM_RST;
      dwell_q     <= wqds_pkg::DWELL_RST;
      home_ms_q   <= wqds_pkg::HOME_RST;
      return_ms_q <= wqds_pkg::RETURN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wqds_pkg::CFG_DEPTH_CM:         depth_q     <= cfg_data_i[wqds_pkg::DEPTH_W-1:0];
        wqds_pkg::CFG_COUNTS_PER_REV:   cpr_q       <= cfg_data_i[wqds_pkg::CPR_W-1:0];
        wqds_pkg::CFG_TURNS_PER_METER:  tpm_q       <= cfg_data_i[wqds_pkg::TPM_W-1:0];
        wqds_pkg::CFG_DWELL_MS:         dwell_q     <= cfg_data_i[wqds_pkg::MS_W-1:0];
        wqds_pkg::CFG_HOME_SETTLE_MS:   home_ms_q   <= cfg_data_i[wqds_pkg::MS_W-1:0];
        wqds_pkg::CFG_RETURN_SETTLE_MS: return_ms_q <= cfg_data_i[wqds_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  // quadrature step and saturating count
  assign quad_idx = {prev_a_q, in_q.hall_a, prev_b_q, in_q.hall_b};
  assign base     = in_q.home_switch ? '0 : pulse_q;
  assign sum      = {base[wqds_pkg::COUNT_BITS-1], base}
                  + (wqds_pkg::COUNT_BITS+1)'(wqds_pkg::QUAD_STEP[quad_idx]);

  always_comb begin
    pulse_d = sum[wqds_pkg::COUNT_BITS-1:0];
    if (sum[wqds_pkg::COUNT_BITS] != sum[wqds_pkg::COUNT_BITS-1]) begin
      pulse_d = sum[wqds_pkg::COUNT_BITS]
              ? {1'b1, {(wqds_pkg::COUNT_BITS-1){1'b0}}}
              : {1'b0, {(wqds_pkg::COUNT_BITS-1){1'b1}}};
    end
  end

  assign divisor = (cpr_q == '0) ? wqds_pkg::CPR_W'(1) : cpr_q;

  wqds_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (pulse_q),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (revs)
  );

  assign cmp_lhs  = {revs, 8'd0};
  assign cmp_rhs  = wqds_pkg::CMP_W'(thr_q);
  assign below    = cmp_lhs < cmp_rhs;
  assign revs_pos = ~revs[wqds_pkg::COUNT_BITS-1] & (revs != '0);

  // waits
  assign wait_inc = (wait_q == '1) ? wait_q : wait_q + wqds_pkg::WAIT_W'(in_q.ms_tick);

  always_comb begin
    case (cmd_i.phase)
      wqds_pkg::PH_SETTLE_HOME:   limit = home_ms_q;
      wqds_pkg::PH_DWELL:         limit = dwell_q;
      wqds_pkg::PH_SETTLE_RETURN: limit = return_ms_q;
      default:                    limit = '0;
    endcase
  end

  // stop count from depth, divide by 100 through reciprocal
  assign depth_ofs  = depth_q - wqds_pkg::DEPTH_W'(wqds_pkg::DEPTH_OFS);
  assign depth_prod = (wqds_pkg::DEPTH_W+wqds_pkg::RECIP_W)'(depth_ofs)
                    * (wqds_pkg::DEPTH_W+wqds_pkg::RECIP_W)'(wqds_pkg::RECIP_100);
  assign nstops     = depth_prod[wqds_pkg::DEPTH_W+wqds_pkg::RECIP_W-1:wqds_pkg::RECIP_SHIFT];
  assign stops_calc = (nstops > wqds_pkg::NSTOP_W'(wqds_pkg::MAX_STOPS))
                    ? wqds_pkg::STOP_W'(wqds_pkg::MAX_STOPS)
                    : nstops[wqds_pkg::STOP_W-1:0];
  assign stop_next  = stop_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_a_q     <= 1'b0;
      prev_b_q     <= 1'b0;
      pulse_q      <= '0;
      stop_q       <= '0;
      stop_total_q <= '0;
      wait_q       <= '0;
      reject_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.count) begin
        prev_a_q <= in_q.hall_a;
        prev_b_q <= in_q.hall_b;
        pulse_q  <= pulse_d;
      end
      if (cmd_i.wait_clr) begin
        wait_q <= '0;
      end else if (cmd_i.wait_step) begin
        wait_q <= wait_inc;
      end
      if (cmd_i.stop_load) begin
        stop_total_q <= stops_calc;
        stop_q       <= '0;
      end else if (cmd_i.stop_clr) begin
        stop_q <= '0;
      end else if (cmd_i.stop_inc) begin
        stop_q <= stop_next;
      end
      if (cmd_i.reject_set) begin
        reject_q <= 1'b1;
      end else if (cmd_i.reject_clr) begin
        reject_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    out_d               = '0;
    out_d.pulse_count   = pulse_q[wqds_pkg::PULSE_W-1:0];
    out_d.revolutions   = revs[wqds_pkg::REV_W-1:0];
    out_d.phase         = cmd_i.phase;
    out_d.rejected      = reject_q;
    case (cmd_i.phase)
      wqds_pkg::PH_HOMING,
      wqds_pkg::PH_RETURNING:  out_d.motor_up = ~in_q.home_switch;
      wqds_pkg::PH_LOWERING:   out_d.motor_down = below;
      wqds_pkg::PH_DWELL:      out_d.reached_meter = stop_next;
      wqds_pkg::PH_FINAL_TURN: out_d.motor_down = ~revs_pos;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      in_q <= in_data_i;
    end
    if (cmd_i.thr) begin
      thr_q <= wqds_pkg::THR_W'({1'b0, stop_q} + 1'b1) * wqds_pkg::THR_W'(tpm_q);
    end
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

  assign status_o.home      = in_q.home_switch;
  assign status_o.start     = in_q.start_req;
  assign status_o.wait_done = wait_inc >= limit;
  assign status_o.below     = below;
  assign status_o.revs_pos  = revs_pos;
  assign status_o.depth_ok  = depth_q > wqds_pkg::DEPTH_W'(wqds_pkg::DEPTH_MIN);
  assign status_o.stops_any = stop_total_q != '0;
  assign status_o.stop_more = stop_next < stop_total_q;
  assign status_o.div_done  = div_done;
  assign status_o.out_free  = ~out_valid_q | out_ready_i;

endmodule

[sv/wqds_ctrl.sv]
module wqds_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  wqds_pkg::dp_status_t status_i,
  output wqds_pkg::dp_cmd_t    cmd_o
);

  wqds_pkg::ctrl_state_e cs_q, cs_d;
  wqds_pkg::phase_e      phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q    <= wqds_pkg::CS_IDLE;
      phase_q <= wqds_pkg::PH_IDLE;
    end else begin
      cs_q    <= cs_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    cs_d    = cs_q;
    phase_d = phase_q;
    case (cs_q)
      wqds_pkg::CS_IDLE:      if (in_valid_i) cs_d = wqds_pkg::CS_COUNT;
      wqds_pkg::CS_COUNT:     cs_d = wqds_pkg::CS_DIV_START;
      wqds_pkg::CS_DIV_START: cs_d = wqds_pkg::CS_DIV_WAIT;
      wqds_pkg::CS_DIV_WAIT:  if (status_i.div_done) cs_d = wqds_pkg::CS_PHASE;
      wqds_pkg::CS_PHASE: begin
        cs_d = wqds_pkg::CS_THRESHOLD;
        case (phase_q)
          wqds_pkg::PH_HOMING:
            if (status_i.home) phase_d = wqds_pkg::PH_SETTLE_HOME;
          wqds_pkg::PH_SETTLE_HOME:
            if (status_i.wait_done) begin
              phase_d = status_i.stops_any ? wqds_pkg::PH_LOWERING : wqds_pkg::PH_RETURNING;
            end
          wqds_pkg::PH_LOWERING:
            if (!status_i.below) phase_d = wqds_pkg::PH_DWELL;
          wqds_pkg::PH_DWELL:
            if (status_i.wait_done) begin
              phase_d = status_i.stop_more ? wqds_pkg::PH_LOWERING : wqds_pkg::PH_RETURNING;
            end
          wqds_pkg::PH_RETURNING:
            if (status_i.home) phase_d = wqds_pkg::PH_SETTLE_RETURN;
          wqds_pkg::PH_SETTLE_RETURN:
            if (status_i.wait_done) phase_d = wqds_pkg::PH_FINAL_TURN;
          wqds_pkg::PH_FINAL_TURN:
            if (status_i.revs_pos) phase_d = wqds_pkg::PH_DONE;
          default: begin
            phase_d = (phase_q == wqds_pkg::PH_DONE) ? wqds_pkg::PH_DONE : wqds_pkg::PH_IDLE;
            if (status_i.start) begin
              phase_d = status_i.depth_ok ? wqds_pkg::PH_HOMING : wqds_pkg::PH_IDLE;
            end
          end
        endcase
      end
      wqds_pkg::CS_THRESHOLD: cs_d = wqds_pkg::CS_EMIT;
      wqds_pkg::CS_EMIT:      if (status_i.out_free) cs_d = wqds_pkg::CS_IDLE;
      default:                cs_d = wqds_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.phase = phase_q;
    in_ready_o  = cs_q == wqds_pkg::CS_IDLE;
    case (cs_q)
      wqds_pkg::CS_IDLE:      cmd_o.latch = in_valid_i;
      wqds_pkg::CS_COUNT: begin
        cmd_o.count = 1'b1;
        cmd_o.thr   = 1'b1;
      end
      wqds_pkg::CS_DIV_START: cmd_o.div_start = 1'b1;
      wqds_pkg::CS_PHASE: begin
        case (phase_q)
          wqds_pkg::PH_HOMING,
          wqds_pkg::PH_RETURNING:
            cmd_o.wait_clr = status_i.home;
          wqds_pkg::PH_SETTLE_HOME: begin
            cmd_o.wait_step = 1'b1;
            cmd_o.stop_clr  = status_i.wait_done;
          end
          wqds_pkg::PH_LOWERING:
            cmd_o.wait_clr = ~status_i.below;
          wqds_pkg::PH_DWELL: begin
            cmd_o.wait_step = 1'b1;
            cmd_o.stop_inc  = status_i.wait_done;
          end
          wqds_pkg::PH_SETTLE_RETURN:
            cmd_o.wait_step = 1'b1;
          wqds_pkg::PH_FINAL_TURN: ;
          default: begin
            cmd_o.reject_set = status_i.start & ~status_i.depth_ok;
            cmd_o.reject_clr = status_i.start & status_i.depth_ok;
            cmd_o.stop_load  = status_i.start & status_i.depth_ok;
          end
        endcase
      end
      wqds_pkg::CS_THRESHOLD: cmd_o.thr = 1'b1;
      wqds_pkg::CS_EMIT:      cmd_o.emit = status_i.out_free;
      default: ;
    endcase
  end

endmodule

[sv/winch_quadrature_depth_sequencer.sv]
// Probe winch sequencer driven by Hall quadrature samples.
// in_i takes one sample item (hall_a, hall_b, home_switch, ms_tick,
// start_req); out_o returns one result item per sample: motor drive lines,
// pulse count, revolutions, sequence phase, meter mark and reject flag.
// Both channels move an item when valid and ready are high at a clock edge.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i; the user
// must write them only while the block is idle, the block does not enforce
// this. Indexes beyond the register list are ignored. A sample passes the
// count, divide, phase, threshold and emit steps in order; the signed divider
// forms revolutions at 4 quotient bits per cycle, then fixes the sign. No new
// sample is taken until the last result has entered the output register.
// A finished result waits in the output register; the next sample is
// accepted meanwhile and its result is held back until the register frees.
// Reset (rst_ni low, asynchronous) clears the count, phase and flags and
// loads the register defaults.
module winch_quadrature_depth_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wqds_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [wqds_pkg::CFG_W-1:0]     cfg_data_i,
  wqds_in_if.sink                        in_i,
  wqds_out_if.source                     out_o
);

  wqds_pkg::dp_cmd_t    cmd;
  wqds_pkg::dp_status_t status;

  wqds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wqds_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_i.data),
    .out_data_o  (out_o.data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

[sim/wqds_monitor.sv]
`timescale 1ns / 1ps

module wqds_monitor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wqds_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [wqds_pkg::CFG_W-1:0]     cfg_data_i,
  wqds_in_if                             in_mon_i,
  wqds_out_if                            out_mon_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import wqds_pkg::*;

  localparam int REJECT_CM   = 100;
  localparam int OFFSET_CM   = 50;
  localparam int STOP_CAP    = 10;
  localparam int PULSE_MAX   = 8388607;
  localparam int PULSE_MIN   = -8388608;

  logic [DEPTH_W-1:0] depth_r;
  logic [CPR_W-1:0]   cpr_r;
  logic [TPM_W-1:0]   tpm_r;
  logic [MS_W-1:0]    dwell_r;
  logic [MS_W-1:0]    home_ms_r;
  logic [MS_W-1:0]    return_ms_r;

  logic               prev_a_r;
  logic               prev_b_r;
  int                 pulse_r;
  phase_e             phase_r;
  logic [STOP_W-1:0]  stop_idx_r;
  logic [STOP_W-1:0]  stop_tot_r;
  logic [WAIT_W-1:0]  wait_r;
  logic               reject_r;

  out_item_t          winch_outputs_q[$];
  out_item_t          got;
  out_item_t          want;

  function automatic int quad_delta(input logic [3:0] idx);
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: return -1;
      4'd2, 4'd4, 4'd11, 4'd13: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic bit short_of_meter(input int revs, input logic [STOP_W-1:0] k);
    longint target;
    target = (longint'(k) + 1) * longint'(tpm_r);
    return longint'(revs) * 256 < target;
  endfunction

  task automatic report_mismatch(input string what, input longint got_v, input longint want_v);
    fail_count_o++;
    $display("%0t: %s mismatch: got %0d, want %0d", $time, what, got_v, want_v);
  endtask

  task automatic advance_winch(input in_item_t s);
    logic [3:0]        idx;
    int                divisor;
    int                revs;
    int                n_stops;
    logic [MS_W-1:0]   limit;
    out_item_t         r;
    idx = {prev_a_r, s.hall_a, prev_b_r, s.hall_b};
    prev_a_r = s.hall_a;
    prev_b_r = s.hall_b;
    if (s.home_switch) pulse_r = 0;
    pulse_r += quad_delta(idx);
    if (pulse_r > PULSE_MAX) pulse_r = PULSE_MAX;
    if (pulse_r < PULSE_MIN) pulse_r = PULSE_MIN;
    divisor = (cpr_r == '0) ? 1 : int'(cpr_r);
    revs = pulse_r / divisor;

    limit = '0;
    if (phase_r == PH_SETTLE_HOME || phase_r == PH_DWELL || phase_r == PH_SETTLE_RETURN) begin
      if (s.ms_tick && wait_r != '1) wait_r++;
      if (phase_r == PH_SETTLE_HOME) limit = home_ms_r;
      else if (phase_r == PH_DWELL) limit = dwell_r;
      else limit = return_ms_r;
    end

    case (phase_r)
      PH_HOMING: begin
        if (s.home_switch) begin
          phase_r = PH_SETTLE_HOME;
          wait_r = '0;
        end
      end
      PH_SETTLE_HOME: begin
        if (wait_r >= limit) begin
          stop_idx_r = '0;
          if (stop_tot_r != '0) phase_r = PH_LOWERING;
          else phase_r = PH_RETURNING;
        end
      end
      PH_LOWERING: begin
        if (!short_of_meter(revs, stop_idx_r)) begin
          phase_r = PH_DWELL;
          wait_r = '0;
        end
      end
      PH_DWELL: begin
        if (wait_r >= limit) begin
          stop_idx_r = stop_idx_r + 1'b1;
          if (stop_idx_r < stop_tot_r) phase_r = PH_LOWERING;
          else phase_r = PH_RETURNING;
        end
      end
      PH_RETURNING: begin
        if (s.home_switch) begin
          phase_r = PH_SETTLE_RETURN;
          wait_r = '0;
        end
      end
      PH_SETTLE_RETURN: begin
        if (wait_r >= limit) phase_r = PH_FINAL_TURN;
      end
      PH_FINAL_TURN: begin
        if (revs >= 1) phase_r = PH_DONE;
      end
      default: begin
        if (phase_r != PH_DONE) phase_r = PH_IDLE;
        if (s.start_req) begin
          if (int'(depth_r) <= REJECT_CM) begin
            reject_r = 1'b1;
            phase_r = PH_IDLE;
          end else begin
            n_stops = (int'(depth_r) - OFFSET_CM) / 100;
            if (n_stops > STOP_CAP) n_stops = STOP_CAP;
            reject_r = 1'b0;
            stop_tot_r = STOP_W'(n_stops);
            stop_idx_r = '0;
            phase_r = PH_HOMING;
          end
        end
      end
    endcase

    r = '0;
    r.pulse_count = pulse_r[PULSE_W-1:0];
    r.revolutions = revs[REV_W-1:0];
    r.phase = phase_r;
    r.rejected = reject_r;
    case (phase_r)
      PH_HOMING, PH_RETURNING: r.motor_up = !s.home_switch;
      PH_LOWERING: r.motor_down = short_of_meter(revs, stop_idx_r);
      PH_DWELL: r.reached_meter = stop_idx_r + 1'b1;
      PH_FINAL_TURN: r.motor_down = revs < 1;
      default: ;
    endcase
    winch_outputs_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_r = 11'd150;
      cpr_r = 12'd490;
      tpm_r = 16'd1358;
      dwell_r = 16'd5000;
      home_ms_r = 16'd1000;
      return_ms_r = 16'd2000;
      prev_a_r = 1'b0;
      prev_b_r = 1'b0;
      pulse_r = 0;
      phase_r = PH_IDLE;
      stop_idx_r = '0;
      stop_tot_r = '0;
      wait_r = '0;
      reject_r = 1'b0;
      winch_outputs_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEPTH_CM: depth_r = cfg_data_i[DEPTH_W-1:0];
          CFG_COUNTS_PER_REV: cpr_r = cfg_data_i[CPR_W-1:0];
          CFG_TURNS_PER_METER: tpm_r = cfg_data_i[TPM_W-1:0];
          CFG_DWELL_MS: dwell_r = cfg_data_i[MS_W-1:0];
          CFG_HOME_SETTLE_MS: home_ms_r = cfg_data_i[MS_W-1:0];
          CFG_RETURN_SETTLE_MS: return_ms_r = cfg_data_i[MS_W-1:0];
          default: ;
        endcase
      end

      if (out_mon_i.valid && out_mon_i.ready) begin
        got = out_mon_i.data;
        if (winch_outputs_q.size() == 0) begin
          report_mismatch("unexpected item, pulse_count", longint'($signed(got.pulse_count)), 0);
        end else begin
          want = winch_outputs_q.pop_front();
          if (got.motor_up != want.motor_up)
            report_mismatch("motor_up", got.motor_up, want.motor_up);
          if (got.motor_down != want.motor_down)
            report_mismatch("motor_down", got.motor_down, want.motor_down);
          if (got.pulse_count != want.pulse_count)
            report_mismatch("pulse_count", longint'($signed(got.pulse_count)),
                            longint'($signed(want.pulse_count)));
          if (got.revolutions != want.revolutions)
            report_mismatch("revolutions", longint'($signed(got.revolutions)),
                            longint'($signed(want.revolutions)));
          if (got.phase != want.phase)
            report_mismatch("phase", got.phase, want.phase);
          if (got.reached_meter != want.reached_meter)
            report_mismatch("reached_meter", got.reached_meter, want.reached_meter);
          if (got.rejected != want.rejected)
            report_mismatch("rejected", got.rejected, want.rejected);
        end
      end

      if (in_mon_i.valid && in_mon_i.ready) advance_winch(in_mon_i.data);
    end
    pending_o = winch_outputs_q.size();
  end

endmodule

[sim/tb_winch_quadrature_depth_sequencer.sv]
`timescale 1ns / 1ps

module tb_winch_quadrature_depth_sequencer;
  import wqds_pkg::*;

  localparam int HOLD_CYCLES       = 300;
  localparam int SETTLE_CYCLES     = 30;
  localparam int ITEMS_PER_SETTING = 230;
  localparam int N_SETTINGS        = 8;

  // depth_cm, counts_per_rev, turns_per_meter_q8, dwell_ms, home_settle_ms, return_settle_ms
  localparam int SETTING_TBL [N_SETTINGS][6] = '{
    '{0,    1,    1,     0,     0,     0},
    '{100,  4095, 65535, 65535, 65535, 65535},
    '{101,  4,    256,   2,     1,     1},
    '{150,  4,    256,   3,     2,     2},
    '{350,  3,    300,   1,     0,     1},
    '{1100, 2,    128,   0,     1,     0},
    '{550,  5,    512,   4,     3,     5},
    '{1100, 1,    1,     0,     0,     0}
  };

  // hall states {a,b}; with the reset state 00 in front, every one of the 16 transitions occurs
  localparam logic [1:0] HALL_WALK [16] = '{
    2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0,
    2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  int                   fail_count;
  int                   pending_count;
  bit                   steady = 1'b0;
  bit                   hold_req = 1'b0;

  logic                 seen_up = 1'b0;
  logic                 seen_down = 1'b0;
  logic [PHASE_W-1:0]   seen_phase = PH_IDLE;
  int                   drum_pos = 0;
  logic [1:0]           gray = 2'd0;

  wqds_in_if  in_ch ();
  wqds_out_if out_ch ();

  winch_quadrature_depth_sequencer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  wqds_monitor i_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) begin
      seen_up <= out_ch.data.motor_up;
      seen_down <= out_ch.data.motor_down;
      seen_phase <= out_ch.data.phase;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_ch.ready <= steady || ($urandom_range(99) >= 9);
    end
  end

  task automatic send_sample(input in_item_t s);
    if (!steady && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= s;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= CFG_W'(value);
    @(negedge clk_i);
  endtask

  task automatic load_setting(input int k);
    write_reg(CFG_DEPTH_CM, SETTING_TBL[k][0]);
    write_reg(CFG_COUNTS_PER_REV, SETTING_TBL[k][1]);
    write_reg(CFG_TURNS_PER_METER, SETTING_TBL[k][2]);
    write_reg(CFG_DWELL_MS, SETTING_TBL[k][3]);
    write_reg(CFG_HOME_SETTLE_MS, SETTING_TBL[k][4]);
    write_reg(CFG_RETURN_SETTLE_MS, SETTING_TBL[k][5]);
    cfg_we <= 1'b0;
  endtask

  // move the drum the way the last result drove it; home closes at position zero
  task automatic run_winch(input int count);
    in_item_t s;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) begin
        s = in_item_t'(5'($urandom_range(31)));
      end else begin
        if (seen_down) begin
          drum_pos++;
          gray++;
        end else if (seen_up && drum_pos > 0) begin
          drum_pos--;
          gray--;
        end
        s.hall_a = gray[0] ^ gray[1];
        s.hall_b = gray[1];
        s.home_switch = drum_pos <= 0;
        s.ms_tick = $urandom_range(1);
        s.start_req = (seen_phase == PH_IDLE || seen_phase == PH_DONE) &&
                      ($urandom_range(3) == 0);
      end
      gray = {s.hall_b, s.hall_a ^ s.hall_b};
      send_sample(s);
    end
  endtask

  initial begin
    in_item_t s;
    cfg_we = 1'b0;
    cfg_idx = CFG_DEPTH_CM;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int k = 0; k < 16; k++) begin
      s.hall_a = HALL_WALK[k][1];
      s.hall_b = HALL_WALK[k][0];
      s.ms_tick = k[0];
      s.home_switch = (k == 5) || (k == 6) || (k == 12);
      s.start_req = (k == 2) || (k == 9);
      send_sample(s);
    end
    send_sample('1);
    send_sample('0);
    gray = 2'd0;
    drain();

    for (int k = 0; k < N_SETTINGS; k++) begin
      load_setting(k);
      @(negedge clk_i);
      steady = (k == 3);
      if (k == 4) hold_req = 1'b1;
      run_winch(ITEMS_PER_SETTING);
      drain();
    end
    steady = 1'b0;

    if (fail_count == 0 && pending_count == 0) begin
      $display("winch_quadrature_depth_sequencer regression: pass");
    end else begin
      $display("winch_quadrature_depth_sequencer regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("winch_quadrature_depth_sequencer regression: fail");
    $finish;
  end

endmodule
